@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMP(name, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/tdma_pkg.sv @@
// ----------------------------------------------------------------------------
// tdma_pkg
// Types, constants and register map of the TDMA slot scheduler.
// ----------------------------------------------------------------------------
package tdma_pkg;

   localparam int TIME_BITS = 64;
   localparam int CNT_W     = $clog2(TIME_BITS);
   localparam int WAIT_W    = 20;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int SKEW_W    = 32;
   localparam int PROD_W    = 24;
   localparam int TGT_W     = PROD_W + 1;
   localparam int CALC_W    = TGT_W + 1;

   localparam logic [1:0]  CONVERGE_NEEDED = 2'd3;
   localparam logic [2:0]  DIVERGE_NEEDED  = 3'd5;
   localparam logic [CALC_W-1:0] MIN_WAIT_US = CALC_W'(100);
   localparam logic [CALC_W-1:0] WAIT_MAX    = CALC_W'((1 << WAIT_W) - 1);

   localparam logic [7:0]  RST_SLOT_ID    = 8'd0;
   localparam logic [7:0]  RST_NUM_SLOTS  = 8'd8;
   localparam logic [15:0] RST_SLOT_DUR   = 16'd500;
   localparam logic [15:0] RST_GUARD      = 16'd50;
   localparam logic [15:0] RST_FRAME      = 16'd4000;
   localparam logic [15:0] RST_CONV_LIMIT = 16'd30;
   localparam logic [15:0] RST_DIV_LIMIT  = 16'd150;
   localparam logic [15:0] RST_FALLBACK   = 16'd800;

   typedef enum logic [2:0] {
      REG_SLOT_ID    = 3'd0,
      REG_NUM_SLOTS  = 3'd1,
      REG_SLOT_DUR   = 3'd2,
      REG_GUARD      = 3'd3,
      REG_FRAME      = 3'd4,
      REG_CONV_LIMIT = 3'd5,
      REG_DIV_LIMIT  = 3'd6,
      REG_FALLBACK   = 3'd7
   } reg_idx_type;

   localparam logic FUNC_SKEW = 1'b0;
   localparam logic FUNC_SLOT = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] clock_skew;
      logic [63:0]        server_time_us;
   } req_type;

   typedef struct packed {
      logic [WAIT_W-1:0] wait_us;
      logic              tdma_active;
      logic              diverged;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tracker_slot_id;
      logic [7:0]  num_slots;
      logic [15:0] slot_duration_us;
      logic [15:0] guard_time_us;
      logic [15:0] frame_interval_us;
      logic [15:0] converge_limit;
      logic [15:0] diverge_limit;
      logic [15:0] fallback_wait_us;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_MUL,
      ST_FIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic capture;
      logic skew_upd;
      logic use_fallback;
      logic div_step;
      logic mul;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_req;
      logic fallback;
      logic div_last;
      logic out_free;
      logic tdma_on;
   } status_type;

endpackage

@@ hw/rtl/tdma_csr.sv @@
// ----------------------------------------------------------------------------
// tdma_csr
// APB configuration registers of the slot scheduler.
// ----------------------------------------------------------------------------
module tdma_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tdma_pkg::ADDR_W-1:0]   paddr,
   input  logic [tdma_pkg::DATA_W-1:0]   pwdata,
   output logic [tdma_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output tdma_pkg::cfg_type             cfg
);
   import tdma_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx   = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SLOT_ID:    cfg_in.tracker_slot_id   = pwdata[7:0];
            REG_NUM_SLOTS:  cfg_in.num_slots         = pwdata[7:0];
            REG_SLOT_DUR:   cfg_in.slot_duration_us  = pwdata[15:0];
            REG_GUARD:      cfg_in.guard_time_us     = pwdata[15:0];
            REG_FRAME:      cfg_in.frame_interval_us = pwdata[15:0];
            REG_CONV_LIMIT: cfg_in.converge_limit    = pwdata[15:0];
            REG_DIV_LIMIT:  cfg_in.diverge_limit     = pwdata[15:0];
            REG_FALLBACK:   cfg_in.fallback_wait_us  = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SLOT_ID:    prdata = {24'd0, cfg_ff.tracker_slot_id};
         REG_NUM_SLOTS:  prdata = {24'd0, cfg_ff.num_slots};
         REG_SLOT_DUR:   prdata = {16'd0, cfg_ff.slot_duration_us};
         REG_GUARD:      prdata = {16'd0, cfg_ff.guard_time_us};
         REG_FRAME:      prdata = {16'd0, cfg_ff.frame_interval_us};
         REG_CONV_LIMIT: prdata = {16'd0, cfg_ff.converge_limit};
         REG_DIV_LIMIT:  prdata = {16'd0, cfg_ff.diverge_limit};
         REG_FALLBACK:   prdata = {16'd0, cfg_ff.fallback_wait_us};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tracker_slot_id   <= RST_SLOT_ID;
         cfg_ff.num_slots         <= RST_NUM_SLOTS;
         cfg_ff.slot_duration_us  <= RST_SLOT_DUR;
         cfg_ff.guard_time_us     <= RST_GUARD;
         cfg_ff.frame_interval_us <= RST_FRAME;
         cfg_ff.converge_limit    <= RST_CONV_LIMIT;
         cfg_ff.diverge_limit     <= RST_DIV_LIMIT;
         cfg_ff.fallback_wait_us  <= RST_FALLBACK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/tdma_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdma_ctrl
// Sequencer for skew reports and slot requests.
// ----------------------------------------------------------------------------
module tdma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tdma_pkg::status_type status,
   output tdma_pkg::cmd_type    cmd,
   output tdma_pkg::state_type  state
);
   import tdma_pkg::*;

   state_type state_ff, state_in;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.is_req) begin
               cmd.skew_upd = 1'b1;
               state_in     = ST_WRITE;
            end else if (status.fallback) begin
               cmd.use_fallback = 1'b1;
               state_in         = ST_WRITE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/tdma_dp.sv @@
// ----------------------------------------------------------------------------
// tdma_dp
// Skew tracking state, serial remainder unit, slot arithmetic and output stage.
// ----------------------------------------------------------------------------
module tdma_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tdma_pkg::cfg_type    cfg,
   input  tdma_pkg::req_type    req_payload,
   input  tdma_pkg::cmd_type    cmd,
   output tdma_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tdma_pkg::rsp_type    rsp_payload
);
   import tdma_pkg::*;

   localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(TIME_BITS - 1);
   localparam logic [CNT_W-1:0] SID_LAST = CNT_W'(TIME_BITS - 8);

   logic [SKEW_W-1:0]    skew_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic                 is_req_ff;
   logic [15:0]          rem_ff;
   logic [7:0]           sid_ff;
   logic [7:0]           srem_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [WAIT_W-1:0]    wait_ff;
   logic                 tdma_on_ff, tdma_on_in;
   logic [1:0]           crun_ff, crun_in;
   logic [2:0]           drun_ff, drun_in;
   rsp_type              out_ff;
   logic                 out_valid_ff, out_valid_in;

   logic [SKEW_W-1:0] mag;
   logic              is_conv, is_div;
   logic [16:0]       rem_sh;
   logic [15:0]       rem_in;
   logic [8:0]        srem_sh;
   logic [7:0]        srem_in;
   logic [7:0]        slot;
   logic [TGT_W-1:0]  target;
   logic [CALC_W-1:0] pos_x, frame_x, tgt_x, wait_a, wait_b;
   logic [WAIT_W-1:0] wait_sat;

   // skew magnitude and zone
   assign mag     = skew_ff[SKEW_W-1] ? (~skew_ff + SKEW_W'(1)) : skew_ff;
   assign is_conv = mag <= {16'd0, cfg.converge_limit};
   assign is_div  = mag > {16'd0, cfg.diverge_limit};

   always_comb begin
      tdma_on_in = tdma_on_ff;
      crun_in    = crun_ff;
      drun_in    = drun_ff;
      if (cmd.skew_upd) begin
         if (is_conv) begin
            crun_in = (crun_ff < CONVERGE_NEEDED) ? crun_ff + 2'd1 : crun_ff;
            drun_in = '0;
            if (crun_in == CONVERGE_NEEDED) begin
               tdma_on_in = 1'b1;
            end
         end else if (is_div) begin
            drun_in = (drun_ff < DIVERGE_NEEDED) ? drun_ff + 3'd1 : drun_ff;
            crun_in = '0;
         end else begin
            crun_in = '0;
            drun_in = '0;
         end
      end
   end

   // one restoring step per cycle while div_step is set; the slot-id remainder steps only while cnt_ff >= SID_LAST
   assign rem_sh  = {rem_ff, time_ff[TIME_BITS-1]};
   assign rem_in  = (rem_sh >= {1'b0, cfg.frame_interval_us}) ?
                    16'(rem_sh - {1'b0, cfg.frame_interval_us}) : rem_sh[15:0];
   assign srem_sh = {srem_ff, sid_ff[7]};
   assign srem_in = (srem_sh >= {1'b0, cfg.num_slots}) ?
                    8'(srem_sh - {1'b0, cfg.num_slots}) : srem_sh[7:0];

   assign slot   = (cfg.num_slots == 8'd0) ? 8'd0 : srem_ff;
   assign target = {1'b0, prod_ff} + TGT_W'(cfg.guard_time_us);

   // wait to the transmit point, wrapped into the next frame when too close
   always_comb begin
      pos_x   = CALC_W'(rem_ff);
      frame_x = CALC_W'(cfg.frame_interval_us);
      tgt_x   = CALC_W'(target);
      wait_a  = (pos_x < tgt_x) ? (tgt_x - pos_x) : (frame_x - pos_x + tgt_x);
      wait_b  = (wait_a < MIN_WAIT_US) ? (wait_a + frame_x) : wait_a;
      wait_sat = (wait_b > WAIT_MAX) ? WAIT_MAX[WAIT_W-1:0] : wait_b[WAIT_W-1:0];
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tdma_on_ff   <= 1'b0;
         crun_ff      <= '0;
         drun_ff      <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         tdma_on_ff   <= tdma_on_in;
         crun_ff      <= crun_in;
         drun_ff      <= drun_in;
         out_valid_ff <= out_valid_in;
         if (cmd.capture) begin
            cnt_ff <= CNT_TOP;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         skew_ff   <= req_payload.clock_skew;
         time_ff   <= req_payload.server_time_us[TIME_BITS-1:0];
         is_req_ff <= (req_payload.func == FUNC_SLOT);
         rem_ff    <= '0;
         srem_ff   <= '0;
         sid_ff    <= cfg.tracker_slot_id;
      end else if (cmd.div_step) begin
         time_ff <= {time_ff[TIME_BITS-2:0], 1'b0};
         rem_ff  <= rem_in;
         if (cnt_ff >= SID_LAST) begin
            srem_ff <= srem_in;
            sid_ff  <= {sid_ff[6:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(slot) * PROD_W'(cfg.slot_duration_us);
      end
      if (cmd.skew_upd) begin
         wait_ff <= '0;
      end else if (cmd.use_fallback) begin
         wait_ff <= WAIT_W'(cfg.fallback_wait_us);
      end else if (cmd.finish) begin
         wait_ff <= wait_sat;
      end
      if (cmd.load_out) begin
         out_ff.wait_us     <= wait_ff;
         out_ff.tdma_active <= tdma_on_ff;
         out_ff.diverged    <= tdma_on_ff && (drun_ff >= DIVERGE_NEEDED);
      end
   end

   assign status.is_req   = is_req_ff;
   assign status.fallback = !tdma_on_ff || (time_ff == '0) ||
                            (cfg.frame_interval_us == 16'd0);
   assign status.div_last = (cnt_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.tdma_on  = tdma_on_ff;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ hw/rtl/tdma_slot_scheduler.sv @@
// ----------------------------------------------------------------------------
// tdma_slot_scheduler
// Skew-driven TDMA enable and per-request wait to the next transmit slot.
// ----------------------------------------------------------------------------
// One item at a time. A skew report goes from ST_DECIDE to ST_WRITE; a slot
// request in TDMA mode passes ST_DECIDE, ST_DIV, ST_MUL, ST_FIN and ST_WRITE,
// where ST_DIV forms the bit-serial remainder of the server time by the frame
// length, one bit per cycle. A request answered with the fallback wait goes
// from ST_DECIDE straight to ST_WRITE. The result sits in an output register,
// so the next item is taken as soon as the previous one is handed there, even
// while it waits on rsp_ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdma_slot_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tdma_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tdma_pkg::rsp_type             rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tdma_pkg::ADDR_W-1:0]   paddr,
   input  logic [tdma_pkg::DATA_W-1:0]   pwdata,
   output logic [tdma_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import tdma_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   state_type  state;

   tdma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tdma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   tdma_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_IMP(a_div_needs_tdma, clock, reset, rsp_valid && rsp_payload.diverged, rsp_payload.tdma_active, "diverged without tdma")
   `ASSERT_NEXT(a_tdma_sticky, clock, reset, status.tdma_on, status.tdma_on, "tdma mode dropped")
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready && (state == ST_DECIDE), "second transaction accepted while busy")

endmodule
